// ----- design/rtc12_pkg.sv -----
// ----------------------------------------------------------------------------
// rtc12_pkg
// Shared types, codes, reset values and calendar helpers for the 12-hour
// real-time clock with calendar.
// ----------------------------------------------------------------------------
package rtc12_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_INC  = 2'd1,
        OP_DEC  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        FLD_HOURS   = 3'd0,
        FLD_MINUTES = 3'd1,
        FLD_SECONDS = 3'd2,
        FLD_DAY     = 3'd3,
        FLD_MONTH   = 3'd4,
        FLD_YEAR    = 3'd5,
        FLD_AMPM    = 3'd6
    } t_field;

    typedef struct packed {
        logic [3:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       is_pm;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_time;

    localparam logic [15:0] TPS_RESET   = 16'd4000;
    localparam logic [3:0]  HOUR_RESET  = 4'd1;
    localparam logic [4:0]  DAY_RESET   = 5'd12;
    localparam logic [3:0]  MONTH_RESET = 4'd6;
    localparam logic [6:0]  YEAR_RESET  = 7'd22;
    localparam logic [6:0]  MIN_SEC_MAX = 7'd59;
    localparam logic [6:0]  HOUR_MAX    = 7'd12;
    localparam logic [6:0]  MONTH_MAX   = 7'd12;
    localparam logic [6:0]  YEAR_MAX    = 7'd99;

    function automatic logic [4:0] days_in_month(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi);
        return (v >= hi || v < lo) ? lo : 7'(v + 7'd1);
    endfunction

    function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] lo,
                                             input logic [6:0] hi);
        return (v <= lo || v > hi) ? hi : 7'(v - 7'd1);
    endfunction

endpackage

// ----- design/rtc_calendar_12_hour.sv -----
// ----------------------------------------------------------------------------
// rtc_calendar_12_hour
// 12-hour real-time clock with AM/PM flag, calendar and field editing.
// ----------------------------------------------------------------------------
// Each input item is a tick, an increment or a decrement of one selected
// field. A tick advances a prescaler unless setting is active; when the
// prescaler reaches ticks_per_second a second elapses and carries through
// seconds, minutes, hours, AM/PM, day, month and year.
// Every input item yields exactly one result item holding the time and date
// after that item. An accepted item is held in the input register, is worked
// out by the update logic into the clock state and the output register, and
// appears on o_valid from the output register.
// One item is taken every cycle while o_stall is low; the combinational
// update logic of the clock state sets that rate.
// When the receiver holds i_stall, the result stays unchanged in the output
// register; the input register still takes one more item, after which
// o_stall rises until the output drains.
// Synchronous reset loads 1:00:00 AM, day 12, month 6, year 22, clears the
// prescaler and sets ticks_per_second to 4000. The user, not the block, must
// write the register through i_cfg_we and i_cfg_wdata only while it is idle.
// ----------------------------------------------------------------------------
module rtc_calendar_12_hour (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_field_select,
    input  logic        i_setting_active,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_hours,
    output logic [5:0]  o_minutes,
    output logic [5:0]  o_seconds,
    output logic        o_is_pm,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_number,
    output logic [6:0]  o_year_in_century
);
    import rtc12_pkg::*;

    logic [15:0] r_tps;
    logic [15:0] r_tick;
    logic [15:0] n_tick;
    t_time       r_time;
    t_time       n_time;
    t_time       r_out;
    logic        r_out_valid;
    logic        r_in_valid;
    logic [1:0]  r_op;
    logic [2:0]  r_sel;
    logic        r_set;
    logic        out_free;
    logic        in_accept;
    logic        advance;
    logic [15:0] limit;
    logic [16:0] tick_next;
    logic [4:0]  dmax;
    logic [3:0]  month_edit;
    logic [4:0]  dmax_new;

    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    assign limit     = (r_tps == 16'd0) ? 16'd1 : r_tps;
    assign tick_next = {1'b0, r_tick} + 17'd1;
    assign dmax      = days_in_month(r_time.month);
    assign month_edit = 4'((r_op == OP_INC)
        ? wrap_up(7'(r_time.month), 7'd1, MONTH_MAX)
        : wrap_down(7'(r_time.month), 7'd1, MONTH_MAX));
    assign dmax_new  = days_in_month(month_edit);

    always_comb begin
        n_time = r_time;
        n_tick = r_tick;
        case (r_op)
            OP_TICK: begin
                if (!r_set) begin
                    if (tick_next >= {1'b0, limit}) begin
                        n_tick = '0;
                        if (r_time.seconds < 6'd59) begin
                            n_time.seconds = r_time.seconds + 6'd1;
                        end else begin
                            n_time.seconds = '0;
                            if (r_time.minutes < 6'd59) begin
                                n_time.minutes = r_time.minutes + 6'd1;
                            end else begin
                                n_time.minutes = '0;
                                if (r_time.hours >= 4'd12) begin
                                    n_time.hours = 4'd1;
                                end else begin
                                    n_time.hours = r_time.hours + 4'd1;
                                    if (r_time.hours == 4'd11) begin
                                        n_time.is_pm = !r_time.is_pm;
                                        // Flipping back to AM starts a new day.
                                        if (r_time.is_pm) begin
                                            if (r_time.day >= dmax) begin
                                                n_time.day = 5'd1;
                                                if (r_time.month >= 4'd12) begin
                                                    n_time.month = 4'd1;
                                                    n_time.year = (r_time.year >= 7'd99)
                                                        ? 7'd0 : r_time.year + 7'd1;
                                                end else begin
                                                    n_time.month = r_time.month + 4'd1;
                                                end
                                            end else begin
                                                n_time.day = r_time.day + 5'd1;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                    end else begin
                        n_tick = tick_next[15:0];
                    end
                end
            end
            OP_INC, OP_DEC: begin
                case (r_sel)
                    FLD_HOURS: n_time.hours = 4'((r_op == OP_INC)
                        ? wrap_up(7'(r_time.hours), 7'd1, HOUR_MAX)
                        : wrap_down(7'(r_time.hours), 7'd1, HOUR_MAX));
                    FLD_MINUTES: n_time.minutes = 6'((r_op == OP_INC)
                        ? wrap_up(7'(r_time.minutes), 7'd0, MIN_SEC_MAX)
                        : wrap_down(7'(r_time.minutes), 7'd0, MIN_SEC_MAX));
                    FLD_SECONDS: n_time.seconds = 6'((r_op == OP_INC)
                        ? wrap_up(7'(r_time.seconds), 7'd0, MIN_SEC_MAX)
                        : wrap_down(7'(r_time.seconds), 7'd0, MIN_SEC_MAX));
                    FLD_DAY: n_time.day = 5'((r_op == OP_INC)
                        ? wrap_up(7'(r_time.day), 7'd1, 7'(dmax))
                        : wrap_down(7'(r_time.day), 7'd1, 7'(dmax)));
                    FLD_MONTH: begin
                        n_time.month = month_edit;
                        if (r_time.day > dmax_new) begin
                            n_time.day = dmax_new;
                        end
                    end
                    FLD_YEAR: n_time.year = (r_op == OP_INC)
                        ? wrap_up(r_time.year, 7'd0, YEAR_MAX)
                        : wrap_down(r_time.year, 7'd0, YEAR_MAX);
                    FLD_AMPM: n_time.is_pm = !r_time.is_pm;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps         <= TPS_RESET;
            r_tick        <= '0;
            r_time.hours  <= HOUR_RESET;
            r_time.minutes <= '0;
            r_time.seconds <= '0;
            r_time.is_pm  <= 1'b0;
            r_time.day    <= DAY_RESET;
            r_time.month  <= MONTH_RESET;
            r_time.year   <= YEAR_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (out_free) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_tick <= n_tick;
                r_time <= n_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_opcode;
            r_sel <= i_field_select;
            r_set <= i_setting_active;
        end
        if (advance) begin
            r_out <= n_time;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_hours           = r_out.hours;
    assign o_minutes         = r_out.minutes;
    assign o_seconds         = r_out.seconds;
    assign o_is_pm           = r_out.is_pm;
    assign o_day_of_month    = r_out.day;
    assign o_month_number    = r_out.month;
    assign o_year_in_century = r_out.year;

    a_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time.hours >= 4'd1 && r_time.hours <= 4'd12)
        else $error("hour register left the range 1 to 12");

    a_day_fits_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time.day >= 5'd1 && r_time.day <= days_in_month(r_time.month))
        else $error("day register beyond the length of the month");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_op) && $stable(r_sel))
        else $error("item in the input register lost while the output was blocked");

    a_second_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_op == OP_INC || r_op == OP_DEC) && r_sel == FLD_SECONDS
        |=> r_time.seconds != $past(r_time.seconds))
        else $error("seconds edit left the seconds unchanged");

endmodule
